// ===== design/svp_pkg.sv =====
package svp_pkg;

    localparam int ONE_Q16          = 65536;
    localparam int EPS_Q16          = 66;
    localparam int SLICE_MIN_PER    = 64;
    localparam int SLICE_VALUE_SPAN = 16;

    localparam int STEP_W  = 21;
    localparam int GAIN_W  = 16;
    localparam int MUL_A_W = 33;
    localparam int MUL_B_W = 17;
    localparam int MUL_P_W = MUL_A_W + MUL_B_W + 1;
    localparam int MIX_MAX = 131071;
    localparam int MIX_MIN = -131072;

    localparam logic [1:0] MODE_WRITE   = 2'd0;
    localparam logic [1:0] MODE_TRIGGER = 2'd1;
    localparam logic [1:0] MODE_TICK    = 2'd2;

    localparam logic REG_SAMPLE_LENGTH = 1'b0;
    localparam logic REG_SLICE_MODE    = 1'b1;

    typedef struct packed {
        logic [1:0]         mode;
        logic [16:0]        address;
        logic signed [15:0] sample_word;
        logic [3:0]         slice_value;
        logic [19:0]        rate;
        logic [15:0]        amplitude;
    } item_t;

    typedef struct packed {
        logic signed [17:0] mixed_sample;
        logic [3:0]         voices_active;
    } mix_t;

    typedef struct packed {
        logic load;
        logic advance;
        logic halt;
    } svp_vb_ctl_t;

endpackage

// ===== design/svp_mult.sv =====
module svp_mult
    import svp_pkg::*;
(
    input  logic                      clk,
    input  logic signed [MUL_A_W-1:0] a,
    input  logic [MUL_B_W-1:0]        b,
    output logic signed [MUL_P_W-1:0] prod
);

    logic signed [MUL_P_W-1:0] prod_reg;
    logic signed [MUL_P_W-1:0] prod_next;

    assign prod_next = a * $signed({1'b0, b});

    always_ff @(posedge clk)
    begin
        prod_reg <= prod_next;
    end

    assign prod = prod_reg;

endmodule

// ===== design/svp_voice_bank.sv =====
module svp_voice_bank
    import svp_pkg::*;
#(
    parameter int VOICE_COUNT = 4,
    parameter int POS_W = 35,
    localparam int VIDX_W = (VOICE_COUNT > 1) ? $clog2(VOICE_COUNT) : 1
)
(
    input  logic                     clk,
    input  logic                     rst_n,
    input  svp_vb_ctl_t              ctl,
    input  logic [VIDX_W-1:0]        wr_idx,
    input  logic [VIDX_W-1:0]        rd_idx,
    input  logic signed [POS_W-1:0]  load_pos,
    input  logic signed [STEP_W-1:0] load_step,
    input  logic signed [POS_W-1:0]  load_end,
    input  logic [GAIN_W-1:0]        load_gain,
    input  logic signed [POS_W-1:0]  limit,
    output logic                     on,
    output logic signed [POS_W-1:0]  pos,
    output logic [GAIN_W-1:0]        gain,
    output logic                     stop
);

    logic                     on_reg   [VOICE_COUNT];
    logic signed [POS_W-1:0]  pos_reg  [VOICE_COUNT];
    logic signed [STEP_W-1:0] step_reg [VOICE_COUNT];
    logic signed [POS_W-1:0]  end_reg  [VOICE_COUNT];
    logic [GAIN_W-1:0]        gain_reg [VOICE_COUNT];

    logic signed [STEP_W-1:0] step;
    logic signed [POS_W-1:0]  end_pos;
    logic signed [POS_W-1:0]  pos_next;
    logic                     passed;

    assign on      = on_reg[rd_idx];
    assign pos     = pos_reg[rd_idx];
    assign step    = step_reg[rd_idx];
    assign end_pos = end_reg[rd_idx];
    assign gain    = gain_reg[rd_idx];

    // end point passed in the direction of travel
    assign passed   = (step > 0) ? (pos > end_pos) : (pos < end_pos);
    assign stop     = (pos < 0) || (pos >= limit) || passed;
    assign pos_next = pos + POS_W'(step);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < VOICE_COUNT; i++)
            begin
                on_reg[i] <= 1'b0;
            end
        end
        else
        begin
            if (ctl.halt)
            begin
                on_reg[rd_idx] <= 1'b0;
            end
            if (ctl.load)
            begin
                on_reg[wr_idx] <= 1'b1;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (ctl.advance)
        begin
            pos_reg[rd_idx] <= pos_next;
        end
        if (ctl.load)
        begin
            pos_reg[wr_idx]  <= load_pos;
            step_reg[wr_idx] <= load_step;
            end_reg[wr_idx]  <= load_end;
            gain_reg[wr_idx] <= load_gain;
        end
    end

endmodule

// ===== design/sample_voice_player_unit.sv =====
// channel  dir  handshake                 payload
// item     in   item_valid / item_stall   item_t: write word, trigger or tick request
// mix      out  mix_valid / mix_stall     mix_t: mixed sample and active voices
// cfg      in   cfg_write                 cfg_index, cfg_data
//
// a write request is done in the idle state; a trigger makes two passes through the shared
// multiplier, and a tick's length is set by the one multiplier
// and the single sample memory port (two reads per voice)
// rst_n clears the sequencer, configuration, voice flags and output valid flag; sample memory is not cleared
// a finished tick waits for a free output register; write and trigger requests are
// still taken while a mix result is stalled
module sample_voice_player_unit
    import svp_pkg::*;
#(
    parameter int SAMPLE_DEPTH = 131072,
    parameter int VOICE_COUNT = 4,
    parameter int SLICE_COUNT = 8
)
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        item_valid,
    output logic        item_stall,
    input  item_t       item,
    output logic        mix_valid,
    input  logic        mix_stall,
    output mix_t        mix,
    input  logic        cfg_write,
    input  logic        cfg_index,
    input  logic [17:0] cfg_data
);

    localparam int LEN_W      = $clog2(SAMPLE_DEPTH + 1);
    localparam int ADDR_W     = $clog2(SAMPLE_DEPTH);
    localparam int POS_W      = LEN_W + 17;
    localparam int VIDX_W     = (VOICE_COUNT > 1) ? $clog2(VOICE_COUNT) : 1;
    localparam int ACC_W      = 48 + $clog2(VOICE_COUNT);
    localparam int SLICE_UNIT = ONE_Q16 / SLICE_COUNT;

    localparam logic [3:0] ST_IDLE    = 4'd0;
    localparam logic [3:0] ST_TRIG_A  = 4'd1;
    localparam logic [3:0] ST_TRIG_B  = 4'd2;
    localparam logic [3:0] ST_TRIG_WR = 4'd3;
    localparam logic [3:0] ST_CHECK   = 4'd4;
    localparam logic [3:0] ST_RD1     = 4'd5;
    localparam logic [3:0] ST_RD2     = 4'd6;
    localparam logic [3:0] ST_MUL1    = 4'd7;
    localparam logic [3:0] ST_MUL2    = 4'd8;
    localparam logic [3:0] ST_ACC     = 4'd9;
    localparam logic [3:0] ST_DONE    = 4'd10;

    logic [3:0]               state_reg,      state_next;
    logic [17:0]              cfg_length_reg;
    logic                     cfg_slice_reg;
    logic [VIDX_W-1:0]        next_voice_reg, next_voice_next;
    logic [VIDX_W-1:0]        voice_idx_reg,  voice_idx_next;
    logic signed [ACC_W-1:0]  acc_reg,        acc_next;
    logic [3:0]               active_reg,     active_next;
    logic                     mix_valid_reg,  mix_valid_next;
    mix_t                     mix_reg,        mix_next;

    logic [MUL_B_W-1:0]       ka_reg,    ka_next;
    logic [MUL_B_W-1:0]       kb_reg,    kb_next;
    logic                     rev_reg,   rev_next;
    logic [19:0]              rate_reg,  rate_next;
    logic [GAIN_W-1:0]        gain_reg,  gain_next;
    logic signed [POS_W-1:0]  a_pos_reg, a_pos_next;
    logic signed [15:0]       s0_reg,    s0_next;
    logic signed [31:0]       interp_reg, interp_next;

    logic signed [15:0]       sample_mem [SAMPLE_DEPTH];
    logic signed [15:0]       rd_word_reg;
    logic [ADDR_W-1:0]        rd_addr;
    logic                     mem_we;

    logic [LEN_W-1:0]         eff_len;
    logic                     item_acc;
    logic                     trig_ok;
    logic [MUL_B_W-1:0]       slice_ka;
    logic [MUL_B_W-1:0]       slice_kb;
    logic                     last_voice;

    logic signed [MUL_A_W-1:0] mul_a;
    logic [MUL_B_W-1:0]        mul_b;
    logic signed [MUL_P_W-1:0] prod;

    svp_vb_ctl_t               vb_ctl;
    logic signed [POS_W-1:0]   vb_limit;
    logic signed [POS_W-1:0]   b_pos;
    logic signed [STEP_W-1:0]  rate_s;
    logic signed [POS_W-1:0]   load_pos;
    logic signed [STEP_W-1:0]  load_step;
    logic signed [POS_W-1:0]   load_end;
    logic                      vb_on;
    logic signed [POS_W-1:0]   vb_pos;
    logic [GAIN_W-1:0]         vb_gain;
    logic                      vb_stop;

    logic signed [16:0]        word_diff;
    logic signed [33:0]        interp_sum;
    logic signed [ACC_W-1:0]   mix_sh;
    logic signed [17:0]        mix_sat;

    assign item_acc = item_valid && !item_stall;
    assign item_stall = (state_reg != ST_IDLE);
    assign mix_valid = mix_valid_reg;
    assign mix = mix_reg;

    assign eff_len = (32'(cfg_length_reg) > 32'(SAMPLE_DEPTH))
                   ? LEN_W'(SAMPLE_DEPTH) : LEN_W'(cfg_length_reg);
    assign vb_limit = (POS_W'(eff_len) <<< 16) - POS_W'(ONE_Q16);
    assign last_voice = (32'(voice_idx_reg) == 32'(VOICE_COUNT - 1));

    // configuration
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_length_reg <= '0;
            cfg_slice_reg  <= 1'b0;
        end
        else if (cfg_write)
        begin
            case (cfg_index)
                REG_SAMPLE_LENGTH: cfg_length_reg <= cfg_data;
                REG_SLICE_MODE:    cfg_slice_reg  <= cfg_data[0];
                default:           cfg_slice_reg  <= cfg_slice_reg;
            endcase
        end
    end

    // sample memory, one write and one registered read
    assign mem_we = item_acc && (item.mode == MODE_WRITE)
                 && (32'(item.address) < 32'(SAMPLE_DEPTH));
    assign rd_addr = (state_reg == ST_RD1)
                   ? vb_pos[ADDR_W+15:16] + ADDR_W'(1) : vb_pos[ADDR_W+15:16];

    always_ff @(posedge clk)
    begin
        if (mem_we)
        begin
            sample_mem[ADDR_W'(item.address)] <= item.sample_word;
        end
        rd_word_reg <= sample_mem[rd_addr];
    end

    // slice offsets per slice value
    always_comb
    begin
        slice_ka = '0;
        slice_kb = '0;
        for (int i = 0; i < SLICE_VALUE_SPAN; i++)
        begin
            if (item.slice_value == 4'(i))
            begin
                slice_ka = MUL_B_W'((i % SLICE_COUNT) * SLICE_UNIT);
                slice_kb = MUL_B_W'(((i % SLICE_COUNT) + 1) * SLICE_UNIT);
            end
        end
    end

    assign trig_ok = cfg_slice_reg
                   ? (32'(eff_len) >= 32'(SLICE_COUNT * SLICE_MIN_PER))
                   : (eff_len != '0);

    // shared multiplier operands
    assign word_diff = 17'(rd_word_reg) - 17'(s0_reg);

    always_comb
    begin
        case (state_reg)
            ST_TRIG_A:
            begin
                mul_a = MUL_A_W'(eff_len);
                mul_b = ka_reg;
            end
            ST_TRIG_B:
            begin
                mul_a = MUL_A_W'(eff_len);
                mul_b = kb_reg;
            end
            ST_RD2:
            begin
                mul_a = MUL_A_W'(word_diff);
                mul_b = MUL_B_W'(vb_pos[15:0]);
            end
            ST_MUL2:
            begin
                mul_a = MUL_A_W'(interp_reg);
                mul_b = MUL_B_W'(vb_gain);
            end
            default:
            begin
                mul_a = '0;
                mul_b = '0;
            end
        endcase
    end

    svp_mult u_mult (
        .clk  (clk),
        .a    (mul_a),
        .b    (mul_b),
        .prod (prod)
    );

    // trigger load values
    assign b_pos     = POS_W'(prod) - POS_W'(ONE_Q16 + EPS_Q16);
    assign rate_s    = STEP_W'(rate_reg);
    assign load_pos  = rev_reg ? b_pos : a_pos_reg;
    assign load_step = rev_reg ? -rate_s : rate_s;
    assign load_end  = rev_reg ? a_pos_reg : b_pos;

    assign vb_ctl.load    = (state_reg == ST_TRIG_WR);
    assign vb_ctl.advance = (state_reg == ST_ACC);
    assign vb_ctl.halt    = (state_reg == ST_CHECK) && vb_on && vb_stop;

    svp_voice_bank #(
        .VOICE_COUNT (VOICE_COUNT),
        .POS_W       (POS_W)
    ) u_voice_bank (
        .clk       (clk),
        .rst_n     (rst_n),
        .ctl       (vb_ctl),
        .wr_idx    (next_voice_reg),
        .rd_idx    (voice_idx_reg),
        .load_pos  (load_pos),
        .load_step (load_step),
        .load_end  (load_end),
        .load_gain (gain_reg),
        .limit     (vb_limit),
        .on        (vb_on),
        .pos       (vb_pos),
        .gain      (vb_gain),
        .stop      (vb_stop)
    );

    assign interp_sum = (34'(s0_reg) <<< 16) + 34'(prod);

    // mix: floor of acc / 2^31, saturated
    assign mix_sh = acc_reg >>> 31;

    always_comb
    begin
        if (mix_sh > ACC_W'(MIX_MAX))
        begin
            mix_sat = 18'(MIX_MAX);
        end
        else if (mix_sh < ACC_W'(MIX_MIN))
        begin
            mix_sat = 18'(MIX_MIN);
        end
        else
        begin
            mix_sat = mix_sh[17:0];
        end
    end

    // sequencer
    always_comb
    begin
        state_next      = state_reg;
        next_voice_next = next_voice_reg;
        voice_idx_next  = voice_idx_reg;
        acc_next        = acc_reg;
        active_next     = active_reg;
        mix_valid_next  = mix_valid_reg;
        mix_next        = mix_reg;
        ka_next         = ka_reg;
        kb_next         = kb_reg;
        rev_next        = rev_reg;
        rate_next       = rate_reg;
        gain_next       = gain_reg;
        a_pos_next      = a_pos_reg;
        s0_next         = s0_reg;
        interp_next     = interp_reg;

        if (mix_valid_reg && !mix_stall)
        begin
            mix_valid_next = 1'b0;
        end

        case (state_reg)
            ST_IDLE:
            begin
                if (item_acc)
                begin
                    case (item.mode)
                        MODE_TRIGGER:
                        begin
                            if (trig_ok)
                            begin
                                ka_next    = cfg_slice_reg ? slice_ka : '0;
                                kb_next    = cfg_slice_reg ? slice_kb
                                                           : MUL_B_W'(ONE_Q16);
                                rev_next   = cfg_slice_reg
                                           && (32'(item.slice_value) >= 32'(SLICE_COUNT));
                                rate_next  = item.rate;
                                gain_next  = item.amplitude;
                                state_next = ST_TRIG_A;
                            end
                        end
                        MODE_TICK:
                        begin
                            acc_next       = '0;
                            active_next    = '0;
                            voice_idx_next = '0;
                            state_next     = ST_CHECK;
                        end
                        default:
                        begin
                            state_next = ST_IDLE;
                        end
                    endcase
                end
            end
            ST_TRIG_A:
            begin
                state_next = ST_TRIG_B;
            end
            ST_TRIG_B:
            begin
                a_pos_next = POS_W'(prod);
                state_next = ST_TRIG_WR;
            end
            ST_TRIG_WR:
            begin
                if (32'(next_voice_reg) == 32'(VOICE_COUNT - 1))
                begin
                    next_voice_next = '0;
                end
                else
                begin
                    next_voice_next = next_voice_reg + VIDX_W'(1);
                end
                state_next = ST_IDLE;
            end
            ST_CHECK:
            begin
                if (vb_on && !vb_stop)
                begin
                    state_next = ST_RD1;
                end
                else if (last_voice)
                begin
                    state_next = ST_DONE;
                end
                else
                begin
                    voice_idx_next = voice_idx_reg + VIDX_W'(1);
                end
            end
            ST_RD1:
            begin
                s0_next    = rd_word_reg;
                state_next = ST_RD2;
            end
            ST_RD2:
            begin
                state_next = ST_MUL1;
            end
            ST_MUL1:
            begin
                interp_next = interp_sum[31:0];
                state_next  = ST_MUL2;
            end
            ST_MUL2:
            begin
                state_next = ST_ACC;
            end
            ST_ACC:
            begin
                acc_next = acc_reg + ACC_W'(prod);
                for (int i = 0; i < 4; i++)
                begin
                    if ((i < VOICE_COUNT) && (32'(voice_idx_reg) == 32'(i)))
                    begin
                        active_next[i] = 1'b1;
                    end
                end
                if (last_voice)
                begin
                    state_next = ST_DONE;
                end
                else
                begin
                    voice_idx_next = voice_idx_reg + VIDX_W'(1);
                    state_next     = ST_CHECK;
                end
            end
            ST_DONE:
            begin
                if (!mix_valid_reg || !mix_stall)
                begin
                    mix_next.mixed_sample  = mix_sat;
                    mix_next.voices_active = active_reg;
                    mix_valid_next         = 1'b1;
                    state_next             = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= ST_IDLE;
            next_voice_reg <= '0;
            voice_idx_reg  <= '0;
            mix_valid_reg  <= 1'b0;
        end
        else
        begin
            state_reg      <= state_next;
            next_voice_reg <= next_voice_next;
            voice_idx_reg  <= voice_idx_next;
            mix_valid_reg  <= mix_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        acc_reg    <= acc_next;
        active_reg <= active_next;
        mix_reg    <= mix_next;
        ka_reg     <= ka_next;
        kb_reg     <= kb_next;
        rev_reg    <= rev_next;
        rate_reg   <= rate_next;
        gain_reg   <= gain_next;
        a_pos_reg  <= a_pos_next;
        s0_reg     <= s0_next;
        interp_reg <= interp_next;
    end

endmodule

// ===== dv/sample_voice_player_unit_checker.sv =====
module sample_voice_player_unit_checker
    import svp_pkg::*;
#(
    parameter int SAMPLE_DEPTH = 131072,
    parameter int VOICE_COUNT = 4,
    parameter int SLICE_COUNT = 8
)
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        item_valid,
    input  logic        item_stall,
    input  item_t       item,
    input  logic        mix_valid,
    input  logic        mix_stall,
    input  mix_t        mix,
    input  logic        cfg_write,
    input  logic        cfg_index,
    input  logic [17:0] cfg_data,
    output int          errors,
    output int          pending
);

    localparam int REPORT_LIMIT = 10;

    shortint     words [SAMPLE_DEPTH];
    bit          voice_live [VOICE_COUNT];
    longint      voice_phase [VOICE_COUNT];
    longint      voice_stride [VOICE_COUNT];
    longint      voice_mark [VOICE_COUNT];
    longint      voice_level [VOICE_COUNT];
    int          rr_voice;
    logic [17:0] length_reg;
    logic        slice_reg;
    mix_t        expected_mixes [$];

    function automatic longint played_length();
        return (length_reg > SAMPLE_DEPTH) ? longint'(SAMPLE_DEPTH) : longint'(length_reg);
    endfunction

    task automatic launch_voice(longint start, longint stride, longint mark,
                                logic [15:0] gain);
        voice_live[rr_voice]   = 1'b1;
        voice_phase[rr_voice]  = start;
        voice_stride[rr_voice] = stride;
        voice_mark[rr_voice]   = mark;
        voice_level[rr_voice]  = longint'(gain);
        rr_voice = (rr_voice + 1) % VOICE_COUNT;
    endtask

    task automatic handle_trigger(item_t req);
        longint span;
        longint first;
        longint last;
        longint unit;
        int     slot;
        span = played_length();
        unit = ONE_Q16 / SLICE_COUNT;
        if (slice_reg)
        begin
            if (span >= SLICE_COUNT * SLICE_MIN_PER)
            begin
                slot  = req.slice_value % SLICE_COUNT;
                first = span * slot * unit;
                last  = span * (slot + 1) * unit - ONE_Q16 - EPS_Q16;
                // upper half of the slice values plays the slice backwards
                if (req.slice_value >= SLICE_COUNT)
                    launch_voice(last, -longint'(req.rate), first, req.amplitude);
                else
                    launch_voice(first, longint'(req.rate), last, req.amplitude);
            end
        end
        else if (span > 0)
        begin
            launch_voice(0, longint'(req.rate), span * ONE_Q16 - ONE_Q16 - EPS_Q16,
                         req.amplitude);
        end
    endtask

    function automatic mix_t mix_tick();
        longint top;
        longint sum;
        longint whole;
        longint frac;
        longint blend;
        longint level;
        logic   passed;
        mix_t   outcome;
        top = (played_length() - 1) * ONE_Q16;
        sum = 0;
        outcome = '0;
        for (int v = 0; v < VOICE_COUNT; v++)
        begin
            if (voice_live[v])
            begin
                if (voice_stride[v] > 0)
                    passed = voice_phase[v] > voice_mark[v];
                else
                    passed = voice_phase[v] < voice_mark[v];
                if (voice_phase[v] < 0 || voice_phase[v] >= top || passed)
                begin
                    voice_live[v] = 1'b0;
                end
                else
                begin
                    whole = voice_phase[v] >>> 16;
                    frac  = voice_phase[v] & 64'hFFFF;
                    blend = longint'(words[whole]) * (ONE_Q16 - frac)
                          + longint'(words[whole + 1]) * frac;
                    sum  += blend * voice_level[v];
                    voice_phase[v] += voice_stride[v];
                    if (v < 4)
                        outcome.voices_active[v] = 1'b1;
                end
            end
        end
        level = sum >>> 31;
        if (level > MIX_MAX)
            level = MIX_MAX;
        if (level < MIX_MIN)
            level = MIX_MIN;
        outcome.mixed_sample = level[17:0];
        return outcome;
    endfunction

    task automatic apply_request(item_t req);
        case (req.mode)
            MODE_WRITE:
            begin
                if (req.address < SAMPLE_DEPTH)
                    words[req.address] = req.sample_word;
            end
            MODE_TRIGGER: handle_trigger(req);
            MODE_TICK:    expected_mixes.push_back(mix_tick());
            default:      ;
        endcase
    endtask

    task automatic check_mix(mix_t got);
        mix_t want;
        if (expected_mixes.size() == 0)
        begin
            errors++;
            if (errors <= REPORT_LIMIT)
                $display("mix result with no tick pending: sample %0d voices %b",
                         $signed(got.mixed_sample), got.voices_active);
        end
        else
        begin
            want = expected_mixes.pop_front();
            if (got.mixed_sample !== want.mixed_sample
                || got.voices_active !== want.voices_active)
            begin
                errors++;
                if (errors <= REPORT_LIMIT)
                    $display("mix mismatch: expected sample %0d voices %b, got sample %0d voices %b",
                             $signed(want.mixed_sample), want.voices_active,
                             $signed(got.mixed_sample), got.voices_active);
            end
        end
    endtask

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int v = 0; v < VOICE_COUNT; v++)
            begin
                voice_live[v]   = 1'b0;
                voice_phase[v]  = 0;
                voice_stride[v] = 0;
                voice_mark[v]   = 0;
                voice_level[v]  = 0;
            end
            rr_voice   = 0;
            length_reg = '0;
            slice_reg  = 1'b0;
            expected_mixes.delete();
            errors  = 0;
            pending = 0;
        end
        else
        begin
            if (cfg_write)
            begin
                if (cfg_index == REG_SAMPLE_LENGTH)
                    length_reg = cfg_data;
                else
                    slice_reg = cfg_data[0];
            end
            // results leave before this edge's request adds a new one
            if (mix_valid && !mix_stall)
                check_mix(mix);
            if (item_valid && !item_stall)
                apply_request(item);
            pending = expected_mixes.size();
        end
    end

endmodule

// ===== dv/sample_voice_player_unit_tb.sv =====
module sample_voice_player_unit_tb;
    import svp_pkg::*;

    localparam int         SAMPLE_DEPTH  = 131072;
    localparam int         PRELOAD_WORDS = 640;
    localparam int         EDGE_WORDS    = 8;
    localparam int         CYCLE_LIMIT   = 4000000;
    localparam int         SETTLE_CYCLES = 40;
    localparam int         RANDOM_PHASES = 12;
    localparam int         PHASE_ITEMS   = 85;
    localparam logic [1:0] MODE_UNUSED   = 2'd3;

    logic        clk;
    logic        rst_n      = 1'b0;
    logic        item_valid = 1'b0;
    logic        item_stall;
    item_t       item       = '0;
    logic        mix_valid;
    logic        mix_stall  = 1'b0;
    mix_t        mix;
    logic        cfg_write  = 1'b0;
    logic        cfg_index  = 1'b0;
    logic [17:0] cfg_data   = '0;

    int send_idle_pct = 0;
    int stall_pct     = 0;
    int cycle_count   = 0;
    int errors;
    int pending;

    sample_voice_player_unit DUT
    (
        .clk(clk),
        .rst_n(rst_n),
        .item_valid(item_valid),
        .item_stall(item_stall),
        .item(item),
        .mix_valid(mix_valid),
        .mix_stall(mix_stall),
        .mix(mix),
        .cfg_write(cfg_write),
        .cfg_index(cfg_index),
        .cfg_data(cfg_data)
    );

    sample_voice_player_unit_checker mix_checker
    (
        .clk(clk),
        .rst_n(rst_n),
        .item_valid(item_valid),
        .item_stall(item_stall),
        .item(item),
        .mix_valid(mix_valid),
        .mix_stall(mix_stall),
        .mix(mix),
        .cfg_write(cfg_write),
        .cfg_index(cfg_index),
        .cfg_data(cfg_data),
        .errors(errors),
        .pending(pending)
    );

    initial
    begin
        clk = 1'b0;
        forever #6 clk = ~clk;
    end

    always @(posedge clk)
        mix_stall <= ($urandom_range(99) < stall_pct);

    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count == CYCLE_LIMIT)
        begin
            $display("[sample_voice_player_unit] ERROR");
            $finish;
        end
    end

    function automatic item_t make_item(logic [1:0] mode);
        item_t      req;
        logic [95:0] bits;
        bits = {$urandom, $urandom, $urandom};
        req = bits[$bits(item_t)-1:0];
        req.mode = mode;
        return req;
    endfunction

    function automatic item_t word_write(int addr, logic signed [15:0] word);
        item_t req;
        req = make_item(MODE_WRITE);
        req.address = addr[16:0];
        req.sample_word = word;
        return req;
    endfunction

    function automatic item_t voice_trigger(logic [3:0] slice, logic [19:0] rate,
                                            logic [15:0] gain);
        item_t req;
        req = make_item(MODE_TRIGGER);
        req.slice_value = slice;
        req.rate = rate;
        req.amplitude = gain;
        return req;
    endfunction

    function automatic logic [19:0] pick_rate();
        int roll;
        roll = $urandom_range(9);
        if (roll == 0)
            return 20'd0;
        else if (roll <= 6)
            return 20'($urandom_range(16384, 196608));
        else if (roll <= 8)
            return 20'($urandom_range(0, 1048575));
        else
            return 20'hFFFFF;
    endfunction

    function automatic logic [15:0] pick_gain();
        int roll;
        roll = $urandom_range(9);
        if (roll <= 7)
            return 16'($urandom_range(0, 32768));
        else if (roll == 8)
            return 16'($urandom_range(32768, 65535));
        else
            return 16'd32768;
    endfunction

    task automatic set_idling(int kind);
        case (kind)
            0:       begin send_idle_pct = 0;  stall_pct = 0;  end
            1:       begin send_idle_pct = 81; stall_pct = 0;  end
            2:       begin send_idle_pct = 0;  stall_pct = 81; end
            default: begin send_idle_pct = 28; stall_pct = 28; end
        endcase
    endtask

    // returns on the edge that takes the request, valid left high
    task automatic send(item_t req);
        while ($urandom_range(99) < send_idle_pct)
        begin
            item_valid <= 1'b0;
            @(posedge clk);
        end
        item <= req;
        item_valid <= 1'b1;
        @(negedge clk);
        while (item_stall)
            @(negedge clk);
        @(posedge clk);
    endtask

    task automatic settle();
        item_valid <= 1'b0;
        @(negedge clk);
        while (pending != 0)
            @(negedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    task automatic configure(logic [17:0] length, logic slices);
        settle();
        cfg_write <= 1'b1;
        cfg_index <= REG_SAMPLE_LENGTH;
        cfg_data  <= length;
        @(posedge clk);
        cfg_index <= REG_SLICE_MODE;
        cfg_data  <= {17'd0, slices};
        @(posedge clk);
        cfg_write <= 1'b0;
    endtask

    initial
    begin
        item_t       req;
        logic [17:0] length;
        logic        slices;
        int          counted;
        int          roll;

        repeat (10) @(posedge clk);
        rst_n <= 1'b1;

        // nothing to play yet
        configure(18'd0, 1'b0);
        send(voice_trigger(4'd0, 20'd65536, 16'd32768));
        send(make_item(MODE_UNUSED));
        send(make_item(MODE_TICK));

        // low words that every random phase's length stays within
        for (int a = 0; a < PRELOAD_WORDS; a++)
        begin
            req = make_item(MODE_WRITE);
            req.address = a[16:0];
            if (a < 2)
                req.sample_word = 16'sh7FFF;
            send(req);
        end

        // words at the start of the last slice and at the top of memory
        for (int a = 0; a < EDGE_WORDS; a++)
        begin
            send(word_write(SAMPLE_DEPTH - SAMPLE_DEPTH / 8 + a, 16'($urandom)));
            send(word_write(SAMPLE_DEPTH - EDGE_WORDS + a, 16'($urandom)));
        end

        // stop at the last sample pair
        configure(18'd2, 1'b0);
        send(voice_trigger(4'd0, 20'd65536, 16'd32768));
        send(make_item(MODE_TICK));
        send(make_item(MODE_TICK));
        configure(18'd1, 1'b0);
        send(voice_trigger(4'd0, 20'd65536, 16'd32768));
        send(make_item(MODE_TICK));

        // saturation both ways
        configure(18'd1024, 1'b0);
        repeat (4) send(voice_trigger(4'd0, 20'd1, 16'hFFFF));
        send(make_item(MODE_TICK));
        send(word_write(0, 16'sh8000));
        send(word_write(1, 16'sh8000));
        send(make_item(MODE_TICK));

        // slices
        configure(18'd511, 1'b1);
        send(voice_trigger(4'd3, 20'd65536, 16'd32768));
        send(make_item(MODE_TICK));
        configure(18'd512, 1'b1);
        send(voice_trigger(4'd0, 20'd65536, 16'd32768));
        send(voice_trigger(4'd15, 20'd0, 16'd32768));
        send(voice_trigger(4'd8, 20'hFFFFF, 16'd32768));
        send(voice_trigger(4'd7, 20'd0, 16'd32768));
        repeat (2) send(make_item(MODE_TICK));
        configure(18'h3FFFF, 1'b1);
        send(voice_trigger(4'd7, 20'd65536, 16'd32768));
        send(voice_trigger(4'd15, 20'd65536, 16'd32768));
        send(make_item(MODE_TICK));
        configure(18'd131072, 1'b0);
        send(voice_trigger(4'd0, 20'd524288, 16'd32768));
        send(make_item(MODE_TICK));

        for (int phase = 0; phase < RANDOM_PHASES; phase++)
        begin
            case (phase % 6)
                0:       begin length = 18'($urandom_range(1, 48));       slices = 1'b0; end
                1:       begin length = 18'($urandom_range(512, PRELOAD_WORDS));
                               slices = 1'b1; end
                2:       begin length = 18'($urandom_range(2, 300));      slices = 1'b0; end
                3:       begin length = 18'($urandom_range(0, 600));      slices = 1'b1; end
                4:       begin length = 18'($urandom_range(300, PRELOAD_WORDS));
                               slices = 1'($urandom_range(1)); end
                default: begin length = 18'($urandom_range(0, 3));        slices = 1'b0; end
            endcase
            configure(length, slices);
            set_idling(phase % 4);
            counted = 0;
            while (counted < PHASE_ITEMS)
            begin
                roll = $urandom_range(99);
                req = make_item(MODE_TICK);
                if (roll < 10)
                begin
                    req.mode = MODE_WRITE;
                    if ($urandom_range(1) == 1)
                        req.address = 17'($urandom_range(0, 2047));
                end
                else if (roll < 32)
                begin
                    req.mode = MODE_TRIGGER;
                    req.rate = pick_rate();
                    req.amplitude = pick_gain();
                end
                else if (roll < 37)
                begin
                    req.mode = MODE_UNUSED;
                end
                send(req);
                if (req.mode != MODE_UNUSED)
                    counted++;
            end
        end

        settle();
        if (errors == 0)
            $display("[sample_voice_player_unit] OK");
        else
            $display("[sample_voice_player_unit] ERROR");
        $finish;
    end

endmodule
